[rtl/core/c8alu_pkg.sv]
// c8alu_pkg: opcode classes, alu sub-codes and reset values shared by the
// register alu core; no dependencies
package c8alu_pkg;

    localparam logic [3:0] CLS_SKIP_EQ_NN = 4'h3;
    localparam logic [3:0] CLS_SKIP_NE_NN = 4'h4;
    localparam logic [3:0] CLS_SKIP_EQ_VY = 4'h5;
    localparam logic [3:0] CLS_LOAD_NN    = 4'h6;
    localparam logic [3:0] CLS_ADD_NN     = 4'h7;
    localparam logic [3:0] CLS_ALU        = 4'h8;
    localparam logic [3:0] CLS_SKIP_NE_VY = 4'h9;
    localparam logic [3:0] CLS_LOAD_I     = 4'hA;
    localparam logic [3:0] CLS_RAND       = 4'hC;
    localparam logic [3:0] CLS_MISC       = 4'hF;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [7:0] MISC_ADD_I  = 8'h1E;
    localparam logic [7:0] MISC_FONT_I = 8'h29;

    localparam logic [3:0]  FLAG_REG       = 4'hF;
    localparam logic [15:0] INDEX_BIAS_RST = 16'd512;

    localparam int unsigned ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_INDEX_BIAS = 3'd0;

endpackage

[rtl/core/chip8_register_alu_core.sv]
// chip8_register_alu_core: executes one chip-8 instruction word per item on
// V0..VF and I; apb-style register port; uses c8alu_pkg
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_ready    | opcode, random_byte
//  out     | output    | o_out_valid / i_out_ready  | skip, reg write, flag, index, unsup
//  apb     | input     | psel, penable, pwrite      | index_bias at byte address 0
//
// two stages: register read into the stage register, then execute into the
// output register; one word per cycle while the output is not stalled
// the register file has one write and two read ports; a write in the same
// cycle as a read is bypassed into the read data, VF lives in its own flop
// synchronous active-low reset clears V, VF, I and both valids and sets index_bias to 512
// a stalled output holds the output register; the stage register still
// takes one more word while it is empty
module chip8_register_alu_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_opcode,
    input  logic [7:0]  i_random_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_skip_next,
    output logic        o_reg_written,
    output logic [3:0]  o_reg_number,
    output logic [7:0]  o_reg_value,
    output logic [7:0]  o_flag_value,
    output logic [15:0] o_index_value,
    output logic        o_unsupported,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [c8alu_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  r_vreg [0:15];
    logic [15:0] r_vvalid;
    logic [7:0]  r_vf;
    logic [15:0] r_index;
    logic [15:0] r_bias;

    logic        r_s1_valid;
    logic [15:0] r_s1_op;
    logic [7:0]  r_s1_rnd;
    logic [7:0]  r_s1_rdx;
    logic [7:0]  r_s1_rdy;

    logic        r_out_valid;
    logic        r_skip;
    logic        r_wr;
    logic [3:0]  r_num;
    logic [7:0]  r_val;
    logic        r_unsup;

    logic        s1_move;
    logic        in_acc;
    logic        cfg_wr;

    logic [3:0]  cls, x, y, n;
    logic [7:0]  nn, vx, vy;
    logic [11:0] nnn;
    logic        skip, unsup, wr_flag, wr_x;
    logic        fval;
    logic [7:0]  xval;
    logic [8:0]  add8;
    logic [16:0] add16;
    logic [10:0] mul5;
    logic [7:0]  n_vf;
    logic [15:0] n_index;
    logic        mem_we;
    logic [3:0]  rd_x, rd_y;

    assign s1_move    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_acc     = i_in_valid && o_in_ready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == c8alu_pkg::ADDR_INDEX_BIAS[2]);
    assign prdata = (paddr[2] == c8alu_pkg::ADDR_INDEX_BIAS[2]) ? {16'd0, r_bias} : 32'd0;

    assign cls = r_s1_op[15:12];
    assign x   = r_s1_op[11:8];
    assign y   = r_s1_op[7:4];
    assign n   = r_s1_op[3:0];
    assign nn  = r_s1_op[7:0];
    assign nnn = r_s1_op[11:0];
    assign vx  = (x == c8alu_pkg::FLAG_REG) ? r_vf : r_s1_rdx;
    assign vy  = (y == c8alu_pkg::FLAG_REG) ? r_vf : r_s1_rdy;

    assign add8  = {1'b0, vx} + {1'b0, vy};
    assign add16 = {1'b0, r_index} + {9'd0, vx};
    assign mul5  = {1'b0, vx, 2'b00} + {3'd0, vx};

    always_comb begin
        skip    = 1'b0;
        unsup   = 1'b0;
        wr_flag = 1'b0;
        wr_x    = 1'b0;
        fval    = 1'b0;
        xval    = 8'd0;
        n_index = r_index;
        case (cls)
            c8alu_pkg::CLS_SKIP_EQ_NN: skip = (vx == nn);
            c8alu_pkg::CLS_SKIP_NE_NN: skip = (vx != nn);
            c8alu_pkg::CLS_SKIP_EQ_VY: begin
                if (n != 4'd0) unsup = 1'b1;
                else skip = (vx == vy);
            end
            c8alu_pkg::CLS_SKIP_NE_VY: begin
                if (n != 4'd0) unsup = 1'b1;
                else skip = (vx != vy);
            end
            c8alu_pkg::CLS_LOAD_NN: begin
                wr_x = 1'b1;
                xval = nn;
            end
            c8alu_pkg::CLS_ADD_NN: begin
                wr_x = 1'b1;
                xval = vx + nn;
            end
            c8alu_pkg::CLS_ALU: begin
                case (n)
                    c8alu_pkg::ALU_MOV: begin
                        wr_x = 1'b1;
                        xval = vy;
                    end
                    c8alu_pkg::ALU_OR: begin
                        wr_x = 1'b1;
                        xval = vx | vy;
                    end
                    c8alu_pkg::ALU_AND: begin
                        wr_x = 1'b1;
                        xval = vx & vy;
                    end
                    c8alu_pkg::ALU_XOR: begin
                        wr_x = 1'b1;
                        xval = vx ^ vy;
                    end
                    c8alu_pkg::ALU_ADD: begin
                        wr_flag = 1'b1;
                        fval    = add8[8];
                        wr_x    = 1'b1;
                        xval    = add8[7:0];
                    end
                    c8alu_pkg::ALU_SUB: begin
                        wr_flag = 1'b1;
                        fval    = (vx > vy);
                        wr_x    = 1'b1;
                        xval    = vx - vy;
                    end
                    c8alu_pkg::ALU_SUBN: begin
                        wr_flag = 1'b1;
                        fval    = (vy > vx);
                        wr_x    = 1'b1;
                        xval    = vy - vx;
                    end
                    c8alu_pkg::ALU_SHR: begin
                        wr_flag = 1'b1;
                        fval    = vx[0];
                        wr_x    = 1'b1;
                        xval    = {1'b0, vx[7:1]};
                    end
                    c8alu_pkg::ALU_SHL: begin
                        wr_flag = 1'b1;
                        fval    = vx[7];
                        wr_x    = 1'b1;
                        xval    = {vx[6:0], 1'b0};
                    end
                    default: unsup = 1'b1;
                endcase
            end
            c8alu_pkg::CLS_LOAD_I: n_index = {4'd0, nnn} - r_bias;
            c8alu_pkg::CLS_RAND: begin
                wr_x = 1'b1;
                xval = r_s1_rnd & nn;
            end
            c8alu_pkg::CLS_MISC: begin
                if (nn == c8alu_pkg::MISC_ADD_I) begin
                    wr_flag = 1'b1;
                    fval    = add16[16];
                    n_index = add16[15:0];
                end else if (nn == c8alu_pkg::MISC_FONT_I) begin
                    n_index = {5'd0, mul5};
                end else begin
                    unsup = 1'b1;
                end
            end
            default: unsup = 1'b1;
        endcase
    end

    always_comb begin
        if (wr_x && (x == c8alu_pkg::FLAG_REG)) n_vf = xval;
        else if (wr_flag) n_vf = {7'd0, fval};
        else n_vf = r_vf;
    end

    assign mem_we = r_s1_valid && s1_move && wr_x && (x != c8alu_pkg::FLAG_REG);
    assign rd_x   = i_opcode[11:8];
    assign rd_y   = i_opcode[7:4];

    // register file, write port and two bypassed read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_vreg[x] <= xval;
        end
        if (in_acc) begin
            if (mem_we && (x == rd_x)) r_s1_rdx <= xval;
            else r_s1_rdx <= r_vvalid[rd_x] ? r_vreg[rd_x] : 8'd0;
            if (mem_we && (x == rd_y)) r_s1_rdy <= xval;
            else r_s1_rdy <= r_vvalid[rd_y] ? r_vreg[rd_y] : 8'd0;
            r_s1_op  <= i_opcode;
            r_s1_rnd <= i_random_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vvalid    <= 16'd0;
            r_vf        <= 8'd0;
            r_index     <= 16'd0;
            r_bias      <= c8alu_pkg::INDEX_BIAS_RST;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) r_bias <= pwdata[15:0];
            if (mem_we) r_vvalid[x] <= 1'b1;
            if (s1_move) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_vf    <= n_vf;
                    r_index <= n_index;
                end
            end
            if (o_in_ready) r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_move) begin
            r_skip  <= skip;
            r_unsup <= unsup;
            r_wr    <= wr_x || wr_flag;
            if (wr_x) begin
                r_num <= x;
                r_val <= xval;
            end else if (wr_flag) begin
                r_num <= c8alu_pkg::FLAG_REG;
                r_val <= {7'd0, fval};
            end else begin
                r_num <= 4'd0;
                r_val <= 8'd0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_skip_next   = r_skip;
    assign o_reg_written = r_wr;
    assign o_reg_number  = r_num;
    assign o_reg_value   = r_val;
    assign o_flag_value  = r_vf;
    assign o_index_value = r_index;
    assign o_unsupported = r_unsup;

endmodule
